@@ design/stn_pkg.sv @@
`timescale 1ns / 1ps

package stn_pkg;

   localparam int ENTRIES    = 4;
   localparam int NAME_CHARS = 6;

   localparam int NAME_W   = 48;
   localparam int SCORE_W  = 20;
   localparam int LINES_W  = 10;
   localparam int LEVEL_W  = 7;
   localparam int HEIGHT_W = 3;
   localparam int IN_W     = 32;
   localparam int PRANK_W  = 2;

   localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int ADDR_W = RANK_W + 1;
   localparam int DEPTH  = 1 << ADDR_W;

   localparam logic [SCORE_W-1:0] MAX_SCORE  = SCORE_W'(999999);
   localparam logic [SCORE_W-1:0] MAX_LINES  = SCORE_W'(999);
   localparam logic [SCORE_W-1:0] MAX_LEVEL  = SCORE_W'(99);
   localparam logic [SCORE_W-1:0] MAX_HEIGHT = SCORE_W'(5);

   localparam logic [7:0]  DASH         = 8'h2D;
   localparam logic [47:0] DEFAULT_NAME = 48'h5245_5941_4C50;

   localparam logic KIND_SUBMIT = 1'b0;
   localparam logic KIND_READ   = 1'b1;

   typedef struct packed {
      logic [NAME_W-1:0]   name;
      logic [SCORE_W-1:0]  score;
      logic [LINES_W-1:0]  lines;
      logic [LEVEL_W-1:0]  level;
      logic [HEIGHT_W-1:0] height;
   } rec_type;

   localparam int REC_W = $bits(rec_type);

   typedef struct packed {
      logic                   kind;
      logic                   mode;
      logic [NAME_W-1:0]      player_name;
      logic signed [IN_W-1:0] score_in;
      logic signed [IN_W-1:0] lines_in;
      logic signed [IN_W-1:0] level_in;
      logic signed [IN_W-1:0] height_in;
      logic [PRANK_W-1:0]     read_rank;
   } req_type;

   typedef struct packed {
      logic                accepted;
      logic [PRANK_W-1:0]  placed_rank;
      logic [NAME_W-1:0]   entry_name;
      logic [SCORE_W-1:0]  entry_score;
      logic [LINES_W-1:0]  entry_lines;
      logic [LEVEL_W-1:0]  entry_level;
      logic [HEIGHT_W-1:0] entry_height;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RESULT
   } state_type;

   function automatic logic [SCORE_W-1:0] sat_val(logic signed [IN_W-1:0] v,
                                                  logic [SCORE_W-1:0] hi);
      logic [SCORE_W-1:0] res;
      if (v < 0) begin
         res = '0;
      end else if (v > $signed({{(IN_W-SCORE_W){1'b0}}, hi})) begin
         res = hi;
      end else begin
         res = v[SCORE_W-1:0];
      end
      return res;
   endfunction

   function automatic logic [NAME_W-1:0] clean_name(logic [NAME_W-1:0] raw_name);
      logic [63:0] src;
      logic [63:0] res;
      logic        ended;
      logic [7:0]  c;
      res   = '0;
      ended = 1'b0;
      if (raw_name[7:0] == 8'h00) begin
         src = {16'h0000, DEFAULT_NAME};
      end else begin
         src = {16'h0000, raw_name};
      end
      for (int i = 0; i < NAME_CHARS && i < 8; i++) begin
         c = src[8*i +: 8];
         if (c == 8'h00) begin
            ended = 1'b1;
         end
         if (ended) begin
            c = DASH;
         end else begin
            if (c inside {[8'h61:8'h7A]}) begin
               c = c - 8'h20;
            end
            if (!(c inside {[8'h41:8'h5A], [8'h30:8'h39]})) begin
               c = DASH;
            end
         end
         res[8*i +: 8] = c;
      end
      return res[NAME_W-1:0];
   endfunction

   function automatic rec_type reset_rec();
      rec_type     r;
      logic [63:0] dashes;
      dashes = '0;
      for (int i = 0; i < NAME_CHARS && i < 8; i++) begin
         dashes[8*i +: 8] = DASH;
      end
      r      = '0;
      r.name = dashes[NAME_W-1:0];
      return r;
   endfunction

endpackage

@@ design/sorted_top_n_insert_top.sv @@
`timescale 1ns / 1ps

// Two score tables of ENTRIES records each, one per mode, kept in descending
// score order in a single synchronous RAM addressed by mode and rank.
// A request is taken when req_valid is high and req_stall is low. A submit
// request saturates its fields, cleans the name and walks the ranks of its
// table once, one rank per cycle: the record goes in at the first rank with
// a lower score and every lower record moves down one rank in the same walk.
// A read request returns the record at the given rank, clamped to the table.
// Each request gives one response on the rsp_ channel, held while rsp_stall
// is high. A submit responds once its one-rank-per-cycle walk through the
// RAM port has passed every rank; a read responds after one RAM lookup.
// Requests are taken one at a time, and the next one is taken while an
// earlier response still waits in the output register.
// Reset clears a valid bit per RAM entry, so every entry reads as a zero
// record with a dashed name until written; no clearing pass is needed.

module sorted_top_n_insert_top
   import stn_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   rec_type           cand;
   logic              mem_wr_en;
   logic [ADDR_W-1:0] mem_wr_addr;
   rec_type           mem_wr_data;
   logic [ADDR_W-1:0] mem_rd_addr;
   rec_type           mem_rd_data;

   stn_prep u_prep (
      .req_payload (req_payload),
      .cand        (cand)
   );

   stn_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .cand        (cand),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   stn_ram #(
      .WIDTH (REC_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

@@ design/stn_ram.sv @@
`timescale 1ns / 1ps

module stn_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/stn_prep.sv @@
`timescale 1ns / 1ps

module stn_prep
   import stn_pkg::*;
(
   input  req_type req_payload,
   output rec_type cand
);

   always_comb begin
      cand.name   = clean_name(req_payload.player_name);
      cand.score  = sat_val(req_payload.score_in, MAX_SCORE);
      cand.lines  = LINES_W'(sat_val(req_payload.lines_in, MAX_LINES));
      cand.level  = LEVEL_W'(sat_val(req_payload.level_in, MAX_LEVEL));
      cand.height = HEIGHT_W'(sat_val(req_payload.height_in, MAX_HEIGHT));
   end

endmodule

@@ design/stn_seq.sv @@
`timescale 1ns / 1ps

module stn_seq
   import stn_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_payload,
   input  rec_type           cand,
   output logic              mem_wr_en,
   output logic [ADDR_W-1:0] mem_wr_addr,
   output rec_type           mem_wr_data,
   output logic [ADDR_W-1:0] mem_rd_addr,
   input  rec_type           mem_rd_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_payload
);

   localparam logic [RANK_W-1:0] LAST_RANK = RANK_W'(ENTRIES - 1);

   state_type         state_ff, state_in;
   logic              kind_ff, kind_in;
   logic              mode_ff, mode_in;
   logic [RANK_W-1:0] rank_ff, rank_in;
   logic [RANK_W-1:0] at_ff, at_in;
   logic              found_ff, found_in;
   rec_type           cand_ff, cand_in;
   rec_type           carry_ff, carry_in;
   logic [DEPTH-1:0]  valid_ff, valid_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [ADDR_W-1:0] cur_addr;
   rec_type           cur_rec;
   logic [RANK_W-1:0] read_rank_sat;
   logic [RANK_W-1:0] first_rank;
   logic [RANK_W-1:0] next_rank;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      mode_ff  <= mode_in;
      rank_ff  <= rank_in;
      at_ff    <= at_in;
      found_ff <= found_in;
      cand_ff  <= cand_in;
      carry_ff <= carry_in;
      rsp_ff   <= rsp_in;
   end

   always_comb begin
      if (32'(req_payload.read_rank) >= 32'(ENTRIES)) begin
         read_rank_sat = LAST_RANK;
      end else begin
         read_rank_sat = RANK_W'(req_payload.read_rank);
      end
      first_rank = (req_payload.kind == KIND_READ) ? read_rank_sat : '0;
      next_rank  = rank_ff + 1'b1;
      cur_addr   = {mode_ff, rank_ff};
      cur_rec    = valid_ff[cur_addr] ? mem_rd_data : reset_rec();
   end

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      mode_in      = mode_ff;
      rank_in      = rank_ff;
      at_in        = at_ff;
      found_in     = found_ff;
      cand_in      = cand_ff;
      carry_in     = carry_ff;
      valid_in     = valid_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = cur_addr;
      mem_wr_data  = cand_ff;
      mem_rd_addr  = {mode_ff, next_rank};

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            mem_rd_addr = {req_payload.mode, first_rank};
            if (req_valid) begin
               kind_in  = req_payload.kind;
               mode_in  = req_payload.mode;
               rank_in  = first_rank;
               cand_in  = cand;
               found_in = 1'b0;
               at_in    = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            carry_in = cur_rec;
            if (kind_ff == KIND_READ) begin
               state_in = ST_RESULT;
            end else begin
               if (found_ff) begin
                  mem_wr_en   = 1'b1;
                  mem_wr_data = carry_ff;
               end else if (cand_ff.score > cur_rec.score) begin
                  mem_wr_en   = 1'b1;
                  mem_wr_data = cand_ff;
                  found_in    = 1'b1;
                  at_in       = rank_ff;
               end
               if (mem_wr_en) begin
                  valid_in[cur_addr] = 1'b1;
               end
               if (rank_ff == LAST_RANK) begin
                  state_in = ST_RESULT;
               end else begin
                  rank_in = next_rank;
               end
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               if (kind_ff == KIND_READ) begin
                  rsp_in.accepted     = 1'b1;
                  rsp_in.placed_rank  = PRANK_W'(rank_ff);
                  rsp_in.entry_name   = carry_ff.name;
                  rsp_in.entry_score  = carry_ff.score;
                  rsp_in.entry_lines  = carry_ff.lines;
                  rsp_in.entry_level  = carry_ff.level;
                  rsp_in.entry_height = carry_ff.height;
               end else if (found_ff) begin
                  rsp_in.accepted     = 1'b1;
                  rsp_in.placed_rank  = PRANK_W'(at_ff);
                  rsp_in.entry_name   = cand_ff.name;
                  rsp_in.entry_score  = cand_ff.score;
                  rsp_in.entry_lines  = cand_ff.lines;
                  rsp_in.entry_level  = cand_ff.level;
                  rsp_in.entry_height = cand_ff.height;
               end else begin
                  rsp_in = '0;
               end
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

@@ design/stn_assert.sv @@
`timescale 1ns / 1ps

module stn_assert
   import stn_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_payload
);

   // A waiting response must not change.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed");

   // The block works on one request at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while busy");

   // A rejected submit reports a zero rank, name, score and line count.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.accepted |->
         rsp_payload.placed_rank == '0 && rsp_payload.entry_name == '0 &&
         rsp_payload.entry_score == '0 && rsp_payload.entry_lines == '0)
      else $error("rejected response not cleared");

   // Stored fields stay within their saturation limits.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         rsp_payload.entry_score <= MAX_SCORE &&
         rsp_payload.entry_lines <= LINES_W'(MAX_LINES) &&
         rsp_payload.entry_level <= LEVEL_W'(MAX_LEVEL) &&
         rsp_payload.entry_height <= HEIGHT_W'(MAX_HEIGHT))
      else $error("response field out of range");

endmodule

bind sorted_top_n_insert_top stn_assert u_stn_assert (.*);

@@ tb/sv/stn_score_checker.sv @@
`timescale 1ns / 1ps

module stn_score_checker
   import stn_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_payload,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_payload,
   output int      fail_count,
   output int      pending,
   output int      placed_count,
   output int      refused_count,
   output int      read_count
);

   localparam logic [NAME_W-1:0] FALLBACK_NAME = {"R", "E", "Y", "A", "L", "P"};

   rec_type board [2][ENTRIES];
   rsp_type replies_due [$];
   rsp_type want;
   rsp_type fresh;

   function automatic logic [SCORE_W-1:0] clamp_to(input logic signed [IN_W-1:0] v,
                                                   input int hi);
      if (v < 0) begin
         return '0;
      end
      if (v > hi) begin
         return SCORE_W'(hi);
      end
      return v[SCORE_W-1:0];
   endfunction

   function automatic logic [NAME_W-1:0] scrub_name(input logic [NAME_W-1:0] raw);
      logic [NAME_W-1:0] src;
      logic [NAME_W-1:0] res;
      logic [7:0]        ch;
      logic              stop;
      src  = (raw[7:0] == 8'h00) ? FALLBACK_NAME : raw;
      res  = '0;
      stop = 1'b0;
      for (int i = 0; i < NAME_CHARS && i < NAME_W / 8; i++) begin
         ch = src[8*i +: 8];
         if (ch == 8'h00) begin
            stop = 1'b1;
         end
         if (stop) begin
            ch = "-";
         end else begin
            if (ch >= "a" && ch <= "z") begin
               ch = ch - 8'd32;
            end
            if (!((ch >= "A" && ch <= "Z") || (ch >= "0" && ch <= "9"))) begin
               ch = "-";
            end
         end
         res[8*i +: 8] = ch;
      end
      return res;
   endfunction

   // Applies one request to the predicted tables and returns the response it should give.
   function automatic rsp_type rank_request(input req_type r);
      rsp_type o;
      rec_type nr;
      rec_type shown;
      int      rk;
      int      slot;
      o     = '0;
      nr    = '0;
      shown = '0;
      if (r.kind == KIND_READ) begin
         rk = int'(r.read_rank);
         if (rk >= ENTRIES) begin
            rk = ENTRIES - 1;
         end
         shown         = board[r.mode][rk];
         o.accepted    = 1'b1;
         o.placed_rank = PRANK_W'(rk);
      end else begin
         nr.score  = clamp_to(r.score_in, 999999);
         nr.lines  = LINES_W'(clamp_to(r.lines_in, 999));
         nr.level  = LEVEL_W'(clamp_to(r.level_in, 99));
         nr.height = HEIGHT_W'(clamp_to(r.height_in, 5));
         slot = -1;
         if (nr.score != 0) begin
            for (int k = 0; k < ENTRIES; k++) begin
               if (slot < 0 && nr.score > board[r.mode][k].score) begin
                  slot = k;
               end
            end
         end
         if (slot >= 0) begin
            nr.name = scrub_name(r.player_name);
            for (int k = ENTRIES - 1; k > slot; k--) begin
               board[r.mode][k] = board[r.mode][k-1];
            end
            board[r.mode][slot] = nr;
            shown         = nr;
            o.accepted    = 1'b1;
            o.placed_rank = PRANK_W'(slot);
         end
      end
      if (o.accepted) begin
         o.entry_name   = shown.name;
         o.entry_score  = shown.score;
         o.entry_lines  = shown.lines;
         o.entry_level  = shown.level;
         o.entry_height = shown.height;
      end
      return o;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int m = 0; m < 2; m++) begin
            for (int k = 0; k < ENTRIES; k++) begin
               board[m][k] = '0;
               for (int c = 0; c < NAME_CHARS && c < NAME_W / 8; c++) begin
                  board[m][k].name[8*c +: 8] = "-";
               end
            end
         end
         replies_due.delete();
         fail_count    = 0;
         placed_count  = 0;
         refused_count = 0;
         read_count    = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (replies_due.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("[%0t] unexpected response: acc %0d rank %0d name %h score %0d",
                           $realtime, rsp_payload.accepted, rsp_payload.placed_rank,
                           rsp_payload.entry_name, rsp_payload.entry_score);
               end
            end else begin
               want = replies_due.pop_front();
               if (rsp_payload.accepted !== want.accepted ||
                   rsp_payload.placed_rank !== want.placed_rank ||
                   rsp_payload.entry_name !== want.entry_name ||
                   rsp_payload.entry_score !== want.entry_score ||
                   rsp_payload.entry_lines !== want.entry_lines ||
                   rsp_payload.entry_level !== want.entry_level ||
                   rsp_payload.entry_height !== want.entry_height) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("[%0t] mismatch, expected acc %0d rank %0d name %h score %0d",
                              $realtime, want.accepted, want.placed_rank, want.entry_name,
                              want.entry_score, " lines %0d level %0d height %0d",
                              want.entry_lines, want.entry_level, want.entry_height);
                     $display("          got acc %0d rank %0d name %h score %0d",
                              rsp_payload.accepted, rsp_payload.placed_rank,
                              rsp_payload.entry_name, rsp_payload.entry_score,
                              " lines %0d level %0d height %0d", rsp_payload.entry_lines,
                              rsp_payload.entry_level, rsp_payload.entry_height);
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            fresh = rank_request(req_payload);
            if (req_payload.kind == KIND_READ) begin
               read_count++;
            end else if (fresh.accepted) begin
               placed_count++;
            end else begin
               refused_count++;
            end
            replies_due.push_back(fresh);
         end
      end
      pending = replies_due.size();
   end

endmodule

@@ tb/sv/tb_sorted_top_n_insert_top.sv @@
`timescale 1ns / 1ps

module tb_sorted_top_n_insert_top
   import stn_pkg::*;
;

   localparam int SILENCE_LIMIT = 5000;

   logic    clock;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   logic req_took = 1'b0;
   bit   steady = 1'b0;
   int   silent_cycles = 0;
   int   recent_scores [$];

   int fail_count;
   int pending;
   int placed_count;
   int refused_count;
   int read_count;

   sorted_top_n_insert_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   stn_score_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_payload   (rsp_payload),
      .fail_count    (fail_count),
      .pending       (pending),
      .placed_count  (placed_count),
      .refused_count (refused_count),
      .read_count    (read_count)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      req_took <= req_valid && !req_stall;
   end

   always @(negedge clock) begin
      rsp_stall <= !reset && !steady && ($urandom_range(99) < 21);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         silent_cycles <= 0;
      end else begin
         silent_cycles <= silent_cycles + 1;
         if (silent_cycles >= SILENCE_LIMIT) begin
            $display("Watchdog expired after %0d cycles without a transfer.", SILENCE_LIMIT);
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   function automatic logic [NAME_W-1:0] pack_name(input string s);
      logic [NAME_W-1:0] v;
      v = '0;
      for (int i = 0; i < s.len() && i < NAME_W / 8; i++) begin
         v[8*i +: 8] = s[i];
      end
      return v;
   endfunction

   function automatic logic [NAME_W-1:0] random_name();
      logic [NAME_W-1:0] v;
      int                p;
      for (int i = 0; i < NAME_W / 8; i++) begin
         p = $urandom_range(99);
         if (p < 55) begin
            v[8*i +: 8] = 8'($urandom_range(8'h7E, 8'h20));
         end else if (p < 75) begin
            v[8*i +: 8] = 8'($urandom_range(255));
         end else if (p < 85) begin
            v[8*i +: 8] = 8'h00;
         end else begin
            v[8*i +: 8] = 8'("a" + $urandom_range(25));
         end
      end
      if ($urandom_range(99) < 6) begin
         v[7:0] = 8'h00;
      end
      return v;
   endfunction

   function automatic logic signed [IN_W-1:0] random_count(input int hi);
      int p;
      p = $urandom_range(99);
      if (p < 70) begin
         return $urandom_range(hi);
      end else if (p < 85) begin
         return $urandom | 32'h8000_0000;
      end
      return $urandom;
   endfunction

   function automatic req_type make_submit(input logic mode, input logic [NAME_W-1:0] name,
                                           input logic signed [IN_W-1:0] score,
                                           input logic signed [IN_W-1:0] lines,
                                           input logic signed [IN_W-1:0] level,
                                           input logic signed [IN_W-1:0] height);
      req_type r;
      r             = '0;
      r.kind        = KIND_SUBMIT;
      r.mode        = mode;
      r.player_name = name;
      r.score_in    = score;
      r.lines_in    = lines;
      r.level_in    = level;
      r.height_in   = height;
      r.read_rank   = PRANK_W'($urandom_range(3));
      return r;
   endfunction

   function automatic req_type make_read(input logic mode, input int rank);
      req_type r;
      r             = '0;
      r.kind        = KIND_READ;
      r.mode        = mode;
      r.player_name = random_name();
      r.score_in    = $urandom;
      r.lines_in    = $urandom;
      r.level_in    = $urandom;
      r.height_in   = $urandom;
      r.read_rank   = PRANK_W'(rank);
      return r;
   endfunction

   // Half the scores follow a rising ladder so the tables keep changing; some repeat for ties.
   function automatic req_type random_request(input int idx);
      req_type r;
      int      pick;
      r             = '0;
      r.kind        = ($urandom_range(99) < 35) ? KIND_READ : KIND_SUBMIT;
      r.mode        = 1'($urandom_range(1));
      r.read_rank   = PRANK_W'($urandom_range(3));
      r.player_name = random_name();
      r.lines_in    = random_count(1200);
      r.level_in    = random_count(120);
      r.height_in   = random_count(7);
      pick = $urandom_range(99);
      if (pick < 50) begin
         r.score_in = idx * 1600 + $urandom_range(3000);
      end else if (pick < 65 && recent_scores.size() > 0) begin
         r.score_in = recent_scores[$urandom_range(recent_scores.size() - 1)];
      end else if (pick < 77) begin
         r.score_in = $urandom_range(999999, 1);
      end else if (pick < 87) begin
         r.score_in = $urandom | 32'h8000_0000;
      end else if (pick < 94) begin
         r.score_in = 0;
      end else begin
         r.score_in = $urandom_range(200, 1);
      end
      if (r.kind == KIND_SUBMIT) begin
         recent_scores.push_back(r.score_in);
         if (recent_scores.size() > 8) begin
            void'(recent_scores.pop_front());
         end
      end
      return r;
   endfunction

   task automatic offer(input req_type r);
      while (!steady && $urandom_range(99) < 21) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      @(negedge clock);
      while (!req_took) begin
         @(negedge clock);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      offer(make_read(1'b0, 0));
      offer(make_read(1'b1, 3));
      offer(make_submit(1'b0, pack_name("zero"), 0, 10, 10, 1));
      offer(make_submit(1'b0, pack_name("neg"), 32'h8000_0000, 5, 5, 2));
      offer(make_submit(1'b0, pack_name("abc"), 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        32'h7FFF_FFFF, 32'h7FFF_FFFF));
      offer(make_submit(1'b0, '0, 1, -1, -100, -1));
      offer(make_submit(1'b0, pack_name("a!b~z9"), 500, 999, 99, 5));
      offer(make_submit(1'b0, pack_name("Second"), 500, 1000, 100, 6));
      offer(make_submit(1'b0, 48'h45_44_43_00_42_41, 999998, 0, 0, 0));
      offer(make_submit(1'b0, 48'hFFFF_FFFF_FFFF, 500, 1, 1, 1));
      offer(make_submit(1'b0, pack_name("@[`{/:"), 501, 2, 2, 3));
      offer(make_submit(1'b0, pack_name("ZAza09"), 1000000, 998, 98, 4));
      for (int k = 0; k < 4; k++) begin
         offer(make_read(1'b0, k));
      end
      offer(make_submit(1'b1, pack_name("Bmode"), 42, 3, 3, 3));
      offer(make_submit(1'b1, pack_name("lo"), 41, 4, 4, 4));
      offer(make_submit(1'b1, pack_name("hi"), 43, 5, 5, 5));
      for (int k = 0; k < 3; k++) begin
         offer(make_read(1'b1, k));
      end
      offer(make_submit(1'b1, pack_name("x"), 32'hFFFF_FFFF, 7, 7, 7));

      for (int i = 0; i < 600; i++) begin
         steady = (i >= 250 && i < 350);
         offer(random_request(i));
      end
      steady = 1'b0;
      req_valid <= 1'b0;

      while (pending != 0) begin
         @(negedge clock);
      end
      repeat (3 * ENTRIES + 12) @(negedge clock);

      $display("Covered %0d placed submits, %0d refused submits and %0d reads on two tables.",
               placed_count, refused_count, read_count);
      if (fail_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("%0d responses were wrong or unexpected.", fail_count);
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
